@@ rtl/tbrl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the token bucket rate limiter.
// No dependencies; every other file imports this package.
package tbrl_pkg;

	localparam int unsigned TOK_W  = 24;
	localparam int unsigned QACC_W = TOK_W + 1;   // accrued tokens, top bit = saturated
	localparam int unsigned REM_W  = 10;          // remainder of division by 1000
	localparam int unsigned TICKQ_W = 15;         // tokens gained in one tick, at most 16778
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	localparam logic [REM_W-1:0] MS_PER_S = REM_W'(1000);

	typedef logic [TOK_W-1:0] tok_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_REQ  = 1'b1
	} kind_t;

	typedef enum logic {
		REG_FILL_RATE  = 1'b0,
		REG_BURST_SIZE = 1'b1
	} reg_idx_t;

	// Derived configuration seen by the bucket datapath.
	typedef struct packed {
		logic load;      // a register is being written this cycle
		tok_t load_rate; // effective rate after the write (refill level)
		tok_t rate;      // effective rate, tokens per second
		tok_t cap;       // bucket capacity
	} cfg_t;

endpackage : tbrl_pkg
`default_nettype wire

@@ rtl/tbrl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for request and response transactions.
// Depends on tbrl_pkg.
interface tbrl_req_if import tbrl_pkg::*; ;
	logic  valid;
	logic  ready;
	logic  kind;
	tok_t  amount;

	modport source(output valid, kind, amount, input ready);
	modport sink(input valid, kind, amount, output ready);
endinterface : tbrl_req_if

interface tbrl_rsp_if import tbrl_pkg::*; ;
	logic  valid;
	logic  ready;
	logic  granted;
	tok_t  tokens_left;

	modport source(output valid, granted, tokens_left, input ready);
	modport sink(input valid, granted, tokens_left, output ready);
endinterface : tbrl_rsp_if
`default_nettype wire

@@ rtl/tbrl_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// APB register file: fill_rate and burst_size, plus derived rate and capacity.
// Depends on tbrl_pkg.
module tbrl_cfg import tbrl_pkg::*; #(
	parameter int unsigned MIN_RATE = 64000
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	localparam tok_t MinRate = TOK_W'(MIN_RATE);

	tok_t fill_q, burst_q, rate_q, cap_q;
	tok_t fill_n, burst_n, rate_n, cap_n;
	logic wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	always_comb begin
		fill_n  = fill_q;
		burst_n = burst_q;
		unique case (idx)
			REG_FILL_RATE:  fill_n  = pwdata[TOK_W-1:0];
			REG_BURST_SIZE: burst_n = pwdata[TOK_W-1:0];
			default: ;
		endcase
		rate_n = (fill_n == '0) ? MinRate : fill_n;
		cap_n  = (burst_n > rate_n) ? burst_n : rate_n;
		if (burst_n != '0 && cap_n < MinRate) begin
			cap_n = MinRate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			burst_q <= '0;
			rate_q  <= MinRate;
			cap_q   <= MinRate;
		end else if (wr) begin
			fill_q  <= fill_n;
			burst_q <= burst_n;
			rate_q  <= rate_n;
			cap_q   <= cap_n;
		end
	end

	always_comb begin
		unique case (idx)
			REG_FILL_RATE:  prdata = DATA_W'(fill_q);
			REG_BURST_SIZE: prdata = DATA_W'(burst_q);
			default:        prdata = '0;
		endcase
	end

	// capacity never drops below the rate, so the refill level is the rate
	assign cfg.load      = wr;
	assign cfg.load_rate = rate_n;
	assign cfg.rate      = rate_q;
	assign cfg.cap       = cap_q;

endmodule : tbrl_cfg
`default_nettype wire

@@ rtl/tbrl_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Bucket datapath: input register, accrual and grant logic, result register.
// Depends on tbrl_pkg and tbrl_if.
module tbrl_core import tbrl_pkg::*; #(
	parameter int unsigned MIN_RATE = 64000
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	tbrl_req_if.sink     req,
	tbrl_rsp_if.source   rsp
);

	localparam int unsigned TSUM_W  = TOK_W + 1;
	localparam int unsigned RECIP_W = 26;
	localparam int unsigned RSH     = 35;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RSH) / 64'd1000);

	// floor(t / 1000) via reciprocal, then one correction step
	function automatic logic [TICKQ_W+REM_W-1:0] div_ms(input logic [TSUM_W-1:0] t);
		logic [TSUM_W+RECIP_W-1:0] prod;
		logic [TICKQ_W-1:0]        q;
		logic [TSUM_W-1:0]         r;
		prod = TSUM_W'(t) * RECIP;
		q    = prod[RSH +: TICKQ_W];
		r    = t - TSUM_W'(q * 25'd1000);
		if (r >= TSUM_W'(MS_PER_S)) begin
			q = q + TICKQ_W'(1);
			r = r - TSUM_W'(MS_PER_S);
		end
		return {q, r[REM_W-1:0]};
	endfunction

	// input stage
	logic  v_s1;
	kind_t kind_s1;
	tok_t  amount_s1;

	// bucket state: accrued whole tokens and the sub-token remainder
	tok_t              stored_q;
	logic [QACC_W-1:0] acc_q;
	logic [REM_W-1:0]  rem_q;

	// result register
	logic rsp_valid_q;
	logic granted_q;
	tok_t left_q;

	logic adv, proc_tick, proc_req, grant;
	logic [TSUM_W-1:0]         tsum;
	logic [TICKQ_W+REM_W-1:0]  dq;
	logic [TOK_W+1:0]          sum;
	tok_t                      avail;

	assign adv       = !(v_s1 && kind_s1 == KIND_REQ && rsp_valid_q && !rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign proc_tick = v_s1 && kind_s1 == KIND_TICK;
	assign proc_req  = v_s1 && kind_s1 == KIND_REQ && adv;

	assign tsum  = TSUM_W'(rem_q) + TSUM_W'(cfg.rate);
	assign dq    = div_ms(tsum);
	assign sum   = (TOK_W+2)'(stored_q) + (TOK_W+2)'(acc_q);
	assign avail = (sum < (TOK_W+2)'(cfg.cap)) ? sum[TOK_W-1:0] : cfg.cap;
	assign grant = amount_s1 <= avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1   <= kind_t'(req.kind);
			amount_s1 <= req.amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= TOK_W'(MIN_RATE);
			acc_q    <= '0;
			rem_q    <= '0;
		end else if (cfg.load) begin
			stored_q <= cfg.load_rate;
			acc_q    <= '0;
			rem_q    <= '0;
		end else if (proc_tick) begin
			// once past every possible capacity, accrual no longer matters
			if (!acc_q[QACC_W-1]) begin
				acc_q <= acc_q + QACC_W'(dq[REM_W +: TICKQ_W]);
				rem_q <= dq[REM_W-1:0];
			end
		end else if (proc_req && grant) begin
			stored_q <= avail - amount_s1;
			acc_q    <= '0;
			rem_q    <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (proc_req) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_req) begin
			granted_q <= grant;
			left_q    <= grant ? (avail - amount_s1) : avail;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.granted     = granted_q;
	assign rsp.tokens_left = left_q;

`ifndef SYNTHESIS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < MS_PER_S)
		else $error("accrual remainder out of range");

	a_stored_cap: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= cfg.cap)
		else $error("stored tokens above capacity");

	a_grant_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc_req && grant && !cfg.load |=> acc_q == '0 && rem_q == '0)
		else $error("grant did not restart accrual");

	a_deny_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		proc_req && !grant && !cfg.load |=> $stable(stored_q) && $stable(acc_q))
		else $error("denial changed bucket state");
`endif

endmodule : tbrl_core
`default_nettype wire

@@ rtl/token_bucket_rate_limiter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Token bucket rate limiter. Each request transaction on req (kind = 1)
// returns one response on rsp: granted, and the tokens left after the grant or
// the tokens available on a denial; tick transactions (kind = 0) advance time
// by one millisecond and return nothing. The block takes one transaction per
// clock and holds no idle gaps: a transaction is registered at the input, then
// processed against the bucket, its response registered at the output; a new
// transaction may follow in every cycle, and a response is held until taken;
// only a response stalled on rsp holds back the input. Refill is tracked as
// whole accrued tokens plus a remainder in thousandths: each tick adds the
// effective rate and splits the sum by 1000 through a reciprocal multiply,
// which is the longest path. Writing fill_rate (byte address 0) or burst_size
// (byte address 4) over APB refills the bucket to the effective rate and
// restarts accrual; write only while no transaction is in flight.
// Depends on tbrl_pkg, tbrl_if, tbrl_cfg, tbrl_core.
module token_bucket_rate_limiter import tbrl_pkg::*; #(
	parameter int unsigned MIN_RATE = 64000   // rate used when fill_rate is zero
) (
	input  logic              clk,
	input  logic              arst_n,
	tbrl_req_if.sink          req,
	tbrl_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	// registers and derived rate/capacity
	tbrl_cfg #(
		.MIN_RATE(MIN_RATE)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// bucket state and grant decision
	tbrl_core #(
		.MIN_RATE(MIN_RATE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule : token_bucket_rate_limiter
`default_nettype wire

@@ tb/token_bucket_rate_limiter_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for token_bucket_rate_limiter: directed and random tick/request
// transactions under several bucket settings, checked against an in-bench bucket predictor.
// Depends on tbrl_pkg, tbrl_if and the token_bucket_rate_limiter RTL.
module token_bucket_rate_limiter_test;
	import tbrl_pkg::*;

	localparam int unsigned MIN_RATE     = 64000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned PHASES       = 13;
	localparam int unsigned RANDOM_OPS   = 25;     // random stimulus picks per phase
	localparam tok_t        TOK_MAX      = {TOK_W{1'b1}};
	localparam logic [39:0] MS_MAX       = {40{1'b1}};

	// One pending transaction. When near_avail is set the amount is picked at
	// launch time as (tokens available now + offset), so boundary requests land
	// exactly on, just under and just over the bucket level.
	typedef struct {
		kind_t kind;
		tok_t  amount;
		bit    near_avail;
		int    offset;
	} bucket_op_t;

	typedef struct {
		logic granted;
		tok_t tokens_left;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	tbrl_req_if req_ch ();
	tbrl_rsp_if rsp_ch ();

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	token_bucket_rate_limiter #(
		.MIN_RATE(MIN_RATE)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ------------------------------------------------------------------
	// Bucket predictor: its own copy of the registers and bucket state.
	// ------------------------------------------------------------------
	tok_t        cfg_fill_rate;
	tok_t        cfg_burst;
	tok_t        bucket_tokens;   // tokens stored at the last grant or refill
	logic [39:0] ms_since;        // ticks since the last grant or refill

	bucket_op_t  op_backlog [$];  // transactions waiting for the driver
	verdict_t    verdict_q [$];   // predicted responses, oldest first

	int unsigned err_count;
	int unsigned n_ticks, n_grants, n_denials, n_checked, n_cfg_writes;
	int unsigned input_stall_cycles;

	// Zero rate selects the minimum rate.
	function automatic longint unsigned bucket_rate();
		return (cfg_fill_rate == 0) ? longint'(MIN_RATE) : longint'(cfg_fill_rate);
	endfunction

	// Capacity is the larger of burst and rate; a nonzero burst never leaves
	// the bucket smaller than the minimum rate.
	function automatic longint unsigned bucket_cap();
		longint unsigned r;
		longint unsigned c;
		r = bucket_rate();
		c = (longint'(cfg_burst) > r) ? longint'(cfg_burst) : r;
		if (cfg_burst != 0 && c < MIN_RATE)
			c = MIN_RATE;
		return c;
	endfunction

	// Lazy refill: accrual over the elapsed ticks, floored, capped at capacity.
	function automatic longint unsigned tokens_available();
		longint unsigned sum;
		sum = longint'(bucket_tokens) + (bucket_rate() * longint'(ms_since)) / 1000;
		return (sum < bucket_cap()) ? sum : bucket_cap();
	endfunction

	// Any register write fills the bucket to min(capacity, rate) and restarts time.
	task automatic refill_bucket();
		bucket_tokens = tok_t'((bucket_cap() < bucket_rate()) ? bucket_cap() : bucket_rate());
		ms_since      = '0;
	endtask

	// Applies one accepted transaction and queues the response it causes.
	task automatic bucket_step(kind_t kind, tok_t amount);
		longint unsigned avail;
		verdict_t v;
		if (kind == KIND_TICK) begin
			if (ms_since != MS_MAX)
				ms_since++;
			n_ticks++;
			return;
		end
		avail = tokens_available();
		if (longint'(amount) <= avail) begin
			bucket_tokens = tok_t'(avail - longint'(amount));
			ms_since      = '0;
			v.granted     = 1'b1;
			v.tokens_left = bucket_tokens;
			n_grants++;
		end else begin
			v.granted     = 1'b0;
			v.tokens_left = tok_t'(avail);
			n_denials++;
		end
		verdict_q.push_back(v);
	endtask

	task automatic flag_error(string msg);
		err_count++;
		$display("ERROR %0t ns: %s", $time, msg);
	endtask

	// Idle length: mostly short, now and then long.
	function automatic int unsigned random_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents the backlog on req, with random gaps.
	// ------------------------------------------------------------------
	bit             src_gaps_on;
	int unsigned    src_gap;
	bucket_op_t     next_op;
	longint         target;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && !req_ch.ready)
				input_stall_cycles++;
			// the accepted transaction updates the predictor before the next
			// one is picked, so a near-available amount sees the current level
			if (req_ch.valid && req_ch.ready)
				bucket_step(kind_t'(req_ch.kind), req_ch.amount);
			if (!req_ch.valid || req_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					req_ch.valid <= 1'b0;
				end else if (op_backlog.size() > 0) begin
					next_op = op_backlog.pop_front();
					if (next_op.near_avail) begin
						target = longint'(tokens_available()) + next_op.offset;
						if (target < 0)
							target = 0;
						if (target > longint'(TOK_MAX))
							target = longint'(TOK_MAX);
						next_op.amount = tok_t'(target);
					end
					req_ch.valid  <= 1'b1;
					req_ch.kind   <= next_op.kind;
					req_ch.amount <= next_op.amount;
					src_gap = (src_gaps_on && $urandom_range(0, 99) < 35) ? random_pause() : 0;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks every response, drives rsp.ready with random stalls.
	// ------------------------------------------------------------------
	bit          sink_stalls_on;
	bit          sink_hold;       // long hold-off, timed by the stimulus process
	int unsigned sink_stall;
	verdict_t    want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (verdict_q.size() == 0) begin
					flag_error($sformatf("response with nothing expected: granted=%0b left=%0d",
						rsp_ch.granted, rsp_ch.tokens_left));
				end else begin
					want = verdict_q.pop_front();
					if (rsp_ch.granted !== want.granted)
						flag_error($sformatf("response %0d: granted=%0b, expected %0b",
							n_checked, rsp_ch.granted, want.granted));
					if (rsp_ch.tokens_left !== want.tokens_left)
						flag_error($sformatf("response %0d: tokens_left=%0d, expected %0d",
							n_checked, rsp_ch.tokens_left, want.tokens_left));
				end
				n_checked++;
			end
			if (sink_hold) begin
				rsp_ch.ready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (sink_stalls_on && $urandom_range(0, 99) < 20)
					sink_stall = random_pause();
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_tick();
		bucket_op_t op;
		op = '{KIND_TICK, tok_t'($urandom), 1'b0, 0};   // amount is don't-care on ticks
		op_backlog.push_back(op);
	endtask

	task automatic push_req(tok_t amount);
		bucket_op_t op;
		op = '{KIND_REQ, amount, 1'b0, 0};
		op_backlog.push_back(op);
	endtask

	task automatic push_near(int offset);
		bucket_op_t op;
		op = '{KIND_REQ, '0, 1'b1, offset};
		op_backlog.push_back(op);
	endtask

	// Mostly requests, many around the current level, plus ticks and odd amounts.
	task automatic push_random_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			repeat ($urandom_range(5, 40)) push_tick();
		else if (r < 40)
			push_tick();
		else if (r < 72)
			push_near(int'($urandom_range(0, 6)) - 3);
		else if (r < 77)
			push_req('0);
		else if (r < 82)
			push_req(TOK_MAX);
		else if (r < 92)
			push_req(tok_t'($urandom_range(0, 2000)));
		else
			push_req(tok_t'($urandom));
	endtask

	// Waits until everything sent has been answered, then lets in-flight
	// ticks retire before the registers may be touched.
	task automatic settle();
		do
			@(negedge clk);
		while (op_backlog.size() != 0 || req_ch.valid || verdict_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup, then access until pready; the register takes the
	// value at the edge that ends the access phase.
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] word);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_FILL_RATE)
			cfg_fill_rate = word[TOK_W-1:0];
		else
			cfg_burst = word[TOK_W-1:0];
		refill_bucket();
		n_cfg_writes++;
	endtask

	// Both registers, random order; the unused upper bits carry junk.
	task automatic program_bucket(tok_t rate, tok_t burst);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_FILL_RATE, {8'($urandom), rate});
			write_reg(REG_BURST_SIZE, {8'($urandom), burst});
		end else begin
			write_reg(REG_BURST_SIZE, {8'($urandom), burst});
			write_reg(REG_FILL_RATE, {8'($urandom), rate});
		end
	endtask

	// Extreme settings first, then random ones.
	tok_t rate_plan  [9] = '{24'd0, TOK_MAX, 24'd1, 24'd1, 24'd0, TOK_MAX,
		24'd63999, 24'd1000, 24'd50};
	tok_t burst_plan [9] = '{24'd0, TOK_MAX, 24'd0, 24'd1, TOK_MAX, 24'd0,
		24'd0, 24'd64001, 24'd20};

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned phase;
		int unsigned k;
		tok_t        new_rate;
		tok_t        new_burst;

		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.kind    = KIND_TICK;
		req_ch.amount  = '0;
		rsp_ch.ready   = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		sink_hold      = 1'b0;
		src_gap        = 0;
		sink_stall     = 0;
		cfg_fill_rate  = '0;
		cfg_burst      = '0;
		refill_bucket();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset bucket: min rate, full at 64000 tokens.
		push_req('0);             // zero request always fits
		push_req(TOK_MAX);        // largest request, denied
		push_near(1);             // one over the full bucket
		push_near(0);             // drains to exactly empty
		push_near(1);             // empty bucket, one token asked
		push_tick();
		push_near(1);             // one tick of accrual, one short
		push_near(0);
		push_tick();
		push_tick();
		push_req(24'd100);
		push_tick();
		push_near(-1);
		push_req(24'h800000);
		push_req(24'h7FFFFF);
		repeat (8) push_tick();
		push_req(TOK_MAX);        // denial keeps accruing
		push_tick();
		push_near(0);
		settle();

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase < 9) begin
				new_rate  = rate_plan[phase];
				new_burst = burst_plan[phase];
			end else begin
				case ($urandom_range(0, 2))
					0: new_rate = tok_t'($urandom_range(1, 5000));
					1: new_rate = tok_t'($urandom_range(0, 200000));
					default: new_rate = tok_t'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0: new_burst = '0;
					1: new_burst = tok_t'($urandom_range(1, 5000));
					2: new_burst = tok_t'($urandom_range(60000, 300000));
					default: new_burst = tok_t'($urandom);
				endcase
			end
			program_bucket(new_rate, new_burst);

			// every fourth phase runs flat out on both sides
			if (phase % 4 == 3) begin
				src_gaps_on    = 1'b0;
				sink_stalls_on = 1'b0;
			end else begin
				src_gaps_on    = $urandom_range(0, 3) != 0;
				sink_stalls_on = $urandom_range(0, 3) != 0;
			end

			if (phase == 1) begin
				// Max rate: empty the bucket, then tick long enough that the
				// accrual passes the 24-bit range before it is capped.
				push_near(0);
				repeat (1010) push_tick();
				push_req(TOK_MAX);
				repeat (3) push_tick();
				push_near(1);
			end

			if (phase == 5) begin
				// Hold the response side off while requests keep coming, so the
				// block fills and backs up its input.
				src_gaps_on = 1'b0;
				sink_hold   = 1'b1;
				for (k = 0; k < 60; k++)
					if (k % 3 == 2)
						push_tick();
					else
						push_near(int'($urandom_range(0, 4)) - 2);
				repeat (80) @(posedge clk);
				sink_hold = 1'b0;
			end

			for (k = 0; k < RANDOM_OPS; k++)
				push_random_op();
			settle();
		end

		// Drain: wait out the backlog, then give responses a bounded time.
		do
			@(negedge clk);
		while (op_backlog.size() != 0 || req_ch.valid);
		for (k = 0; k < 5000 && verdict_q.size() != 0; k++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (verdict_q.size() != 0)
			flag_error($sformatf("%0d responses never arrived", verdict_q.size()));

		$display("Covered %0d ticks, %0d grants, %0d denials over %0d register writes",
			n_ticks, n_grants, n_denials, n_cfg_writes);
		$display("Checked %0d responses; input held off for %0d cycles; %0d mismatches",
			n_checked, input_stall_cycles, err_count);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog, far above the slowest legal run.
	initial begin
		#5_000_000;
		$display("Timeout: %0d responses outstanding", verdict_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule : token_bucket_rate_limiter_test
